FILE: src/epe_pkg.sv
// ----------------------------------------------------------------------------
// Erasure parity encoder package
// Shared constants, types and the GF(2^8) multiply used by the encoder blocks.
// ----------------------------------------------------------------------------
package epe_pkg;

   // Low byte of the field polynomial x^8+x^4+x^3+x^2+1.
   localparam logic [7:0] GF_LOW_POLY = 8'h1D;

   // Largest number of parity rows a result can name.
   localparam int OUT_ROW_LIMIT = 8;

   // Configuration register indexes.
   localparam logic [7:0] CSR_DATA_COUNT   = 8'd0;
   localparam logic [7:0] CSR_PARITY_COUNT = 8'd1;

   // Column queue depth.
   localparam int QUEUE_DEPTH = 2;

   // Status of the column queue as seen by its neighbours.
   typedef struct packed {
      logic empty;
      logic full;
   } q_status_type;

   // Multiply two field elements, one shift-and-reduce step per bit.
   function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
      logic [7:0] x;
      logic [7:0] acc;
      x   = a;
      acc = '0;
      for (int n = 0; n < 8; n++) begin
         if (b[n]) begin
            acc = acc ^ x;
         end
         x = {x[6:0], 1'b0} ^ (x[7] ? GF_LOW_POLY : 8'h00);
      end
      return acc;
   endfunction

endpackage

FILE: src/erasure_parity_encoder_gf256_top.sv
// The first parity byte of a column passes through the column queue and then the output
// register after its last data byte has been accepted.
// One data byte per cycle goes in while the queue is not full, and one parity byte per
// cycle goes out while the output is not stalled.
// A two-entry column queue lets the front end start the next column while one drains.
// Reset is synchronous and active high: k = 1, m = 1, all sums zero, all powers one.
// ----------------------------------------------------------------------------
// Erasure parity encoder top level
// Vandermonde-row parity encoder over GF(2^8) with configuration registers.
// ----------------------------------------------------------------------------
module erasure_parity_encoder_gf256_top #(
   parameter int MAX_DATA   = 16,
   parameter int MAX_PARITY = 8
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_data_byte,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_parity_byte,
   output logic [2:0] rsp_parity_row,
   output logic       rsp_last_of_column,
   input  logic       csr_valid,
   output logic       csr_ready,
   input  logic [7:0] csr_index,
   input  logic [7:0] csr_data
);
   import epe_pkg::*;

   localparam int ROWS = (MAX_PARITY < OUT_ROW_LIMIT) ? MAX_PARITY : OUT_ROW_LIMIT;

   logic [4:0]       data_count_ff;
   logic [4:0]       data_count_in;
   logic [3:0]       parity_count_ff;
   logic [3:0]       parity_count_in;
   logic             csr_acc;
   logic             clear_column;
   logic [4:0]       k_eff;
   logic [3:0]       m_eff;
   logic             push;
   logic             pop;
   logic [ROWS*8-1:0] column_sums;
   logic [ROWS*8-1:0] head_data;
   q_status_type     q_status;

   // Configuration registers; a write to a listed register restarts the column.
   assign csr_ready    = 1'b1;
   assign csr_acc      = csr_valid && csr_ready;
   assign clear_column = csr_acc &&
                         ((csr_index == CSR_DATA_COUNT) || (csr_index == CSR_PARITY_COUNT));

   always_comb begin
      data_count_in   = data_count_ff;
      parity_count_in = parity_count_ff;
      if (csr_acc) begin
         unique case (csr_index)
            CSR_DATA_COUNT:   data_count_in   = csr_data[4:0];
            CSR_PARITY_COUNT: parity_count_in = csr_data[3:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         data_count_ff   <= 5'd1;
         parity_count_ff <= 4'd1;
      end else begin
         data_count_ff   <= data_count_in;
         parity_count_ff <= parity_count_in;
      end
   end

   // Effective counts, saturated into their legal ranges.
   always_comb begin
      k_eff = data_count_ff;
      if (data_count_ff == 5'd0) begin
         k_eff = 5'd1;
      end else if (int'(data_count_ff) > MAX_DATA) begin
         k_eff = 5'(MAX_DATA);
      end
      m_eff = parity_count_ff;
      if (parity_count_ff == 4'd0) begin
         m_eff = 4'd1;
      end else if (int'(parity_count_ff) > ROWS) begin
         m_eff = 4'(ROWS);
      end
   end

   epe_front #(
      .ROWS (ROWS)
   ) u_front (
      .clock        (clock),
      .reset        (reset),
      .clear_column (clear_column),
      .k_eff        (k_eff),
      .m_eff        (m_eff),
      .byte_valid   (req_valid),
      .data_byte    (req_data_byte),
      .q_status     (q_status),
      .byte_stall   (req_stall),
      .push         (push),
      .column_sums  (column_sums)
   );

   epe_queue #(
      .WIDTH (ROWS * 8)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (column_sums),
      .pop       (pop),
      .head_data (head_data),
      .q_status  (q_status)
   );

   epe_back #(
      .ROWS (ROWS)
   ) u_back (
      .clock              (clock),
      .reset              (reset),
      .m_eff              (m_eff),
      .head_data          (head_data),
      .q_status           (q_status),
      .pop                (pop),
      .rsp_stall          (rsp_stall),
      .rsp_valid          (rsp_valid),
      .rsp_parity_byte    (rsp_parity_byte),
      .rsp_parity_row     (rsp_parity_row),
      .rsp_last_of_column (rsp_last_of_column)
   );

endmodule

FILE: src/epe_front.sv
// ----------------------------------------------------------------------------
// Erasure parity encoder front end
// Accepts data bytes, updates one running parity sum per row and hands each
// finished column of sums to the column queue.
// ----------------------------------------------------------------------------
module epe_front #(
   parameter int ROWS = 8
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 clear_column,
   input  logic [4:0]           k_eff,
   input  logic [3:0]           m_eff,
   input  logic                 byte_valid,
   input  logic [7:0]           data_byte,
   input  epe_pkg::q_status_type q_status,
   output logic                 byte_stall,
   output logic                 push,
   output logic [ROWS*8-1:0]    column_sums
);
   import epe_pkg::*;

   logic [7:0] sums_ff   [ROWS];
   logic [7:0] sums_in   [ROWS];
   logic [7:0] pows_ff   [ROWS];
   logic [7:0] pows_in   [ROWS];
   logic [7:0] sums_next [ROWS];
   logic [4:0] pos_ff;
   logic [4:0] pos_in;
   logic       byte_acc;
   logic       col_done;

   // A byte is held off only while the queue has no room for a column.
   assign byte_stall = q_status.full;
   assign byte_acc   = byte_valid && !byte_stall;
   assign col_done   = byte_acc && (pos_ff == (k_eff - 5'd1));
   assign push       = col_done;

   // One multiply-accumulate and one power step per active row.
   for (genvar i = 0; i < ROWS; i++) begin : g_row
      logic [7:0] base;
      assign base = 8'({3'b000, k_eff} + 8'(i + 1));
      assign sums_next[i] = ((4'(i) < m_eff) ? (sums_ff[i] ^ gf_mul(pows_ff[i], data_byte))
                                             : sums_ff[i]);
      assign column_sums[i*8 +: 8] = sums_next[i];

      always_comb begin
         sums_in[i] = sums_ff[i];
         pows_in[i] = pows_ff[i];
         if (clear_column || col_done) begin
            sums_in[i] = 8'h00;
            pows_in[i] = 8'h01;
         end else if (byte_acc && (4'(i) < m_eff)) begin
            sums_in[i] = sums_next[i];
            pows_in[i] = gf_mul(pows_ff[i], base);
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            sums_ff[i] <= 8'h00;
            pows_ff[i] <= 8'h01;
         end else begin
            sums_ff[i] <= sums_in[i];
            pows_ff[i] <= pows_in[i];
         end
      end
   end

   // Position of the next byte within the column.
   always_comb begin
      pos_in = pos_ff;
      if (clear_column || col_done) begin
         pos_in = '0;
      end else if (byte_acc) begin
         pos_in = pos_ff + 5'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= '0;
      end else begin
         pos_ff <= pos_in;
      end
   end

endmodule

FILE: src/epe_queue.sv
// ----------------------------------------------------------------------------
// Erasure parity encoder column queue
// Short queue of finished columns between the front end and the output side.
// ----------------------------------------------------------------------------
module epe_queue #(
   parameter int WIDTH = 64
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  logic [WIDTH-1:0]     push_data,
   input  logic                 pop,
   output logic [WIDTH-1:0]     head_data,
   output epe_pkg::q_status_type q_status
);
   import epe_pkg::*;

   localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CW = $clog2(QUEUE_DEPTH + 1);

   logic [WIDTH-1:0] slots_ff [QUEUE_DEPTH];
   logic [PW-1:0]    wr_ptr_ff;
   logic [PW-1:0]    wr_ptr_in;
   logic [PW-1:0]    rd_ptr_ff;
   logic [PW-1:0]    rd_ptr_in;
   logic [CW-1:0]    count_ff;
   logic [CW-1:0]    count_in;

   assign head_data      = slots_ff[rd_ptr_ff];
   assign q_status.empty = (count_ff == '0);
   assign q_status.full  = (count_ff == CW'(QUEUE_DEPTH));

   // Pointer and fill count update.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + PW'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + PW'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CW'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Column storage needs no reset.
   always_ff @(posedge clock) begin
      if (push) begin
         slots_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

FILE: src/epe_back.sv
// ----------------------------------------------------------------------------
// Erasure parity encoder back end
// Unloads one column at a time from the queue and sends its parity bytes in
// row order through an output register, marking the last of the column.
// ----------------------------------------------------------------------------
module epe_back #(
   parameter int ROWS = 8
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic [3:0]           m_eff,
   input  logic [ROWS*8-1:0]    head_data,
   input  epe_pkg::q_status_type q_status,
   output logic                 pop,
   input  logic                 rsp_stall,
   output logic                 rsp_valid,
   output logic [7:0]           rsp_parity_byte,
   output logic [2:0]           rsp_parity_row,
   output logic                 rsp_last_of_column
);
   import epe_pkg::*;

   localparam int RIW = (ROWS > 1) ? $clog2(ROWS) : 1;

   logic [7:0] head_bytes [ROWS];
   logic [2:0] row_ff;
   logic [2:0] row_in;
   logic       valid_ff;
   logic       valid_in;
   logic [7:0] byte_ff;
   logic [7:0] byte_in;
   logic [2:0] prow_ff;
   logic [2:0] prow_in;
   logic       last_ff;
   logic       last_in;
   logic       load;
   logic       row_last;

   for (genvar i = 0; i < ROWS; i++) begin : g_unpack
      assign head_bytes[i] = head_data[i*8 +: 8];
   end

   // Load a new byte whenever the queue holds a column and the output register is free or being taken.
   assign load     = !q_status.empty && (!valid_ff || !rsp_stall);
   assign row_last = ({1'b0, row_ff} == (m_eff - 4'd1));
   assign pop      = load && row_last;

   always_comb begin
      row_in   = row_ff;
      valid_in = valid_ff;
      byte_in  = byte_ff;
      prow_in  = prow_ff;
      last_in  = last_ff;
      if (load) begin
         valid_in = 1'b1;
         byte_in  = head_bytes[row_ff[RIW-1:0]];
         prow_in  = row_ff;
         last_in  = row_last;
         row_in   = row_last ? 3'd0 : row_ff + 3'd1;
      end else if (valid_ff && !rsp_stall) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         row_ff   <= row_in;
         valid_ff <= valid_in;
      end
   end

   // Output payload needs no reset.
   always_ff @(posedge clock) begin
      byte_ff <= byte_in;
      prow_ff <= prow_in;
      last_ff <= last_in;
   end

   assign rsp_valid          = valid_ff;
   assign rsp_parity_byte    = byte_ff;
   assign rsp_parity_row     = prow_ff;
   assign rsp_last_of_column = last_ff;

endmodule
